// File: rtl/kpt_pkg.sv
// Package for the keyed peer table: command and status codes, beat payload types,
// and the control and status structs between the controller and the datapath.
// No dependencies.
package kpt_pkg;

    // Command codes carried in the input beat.
    localparam logic [1:0] CMD_UPSERT  = 2'd0;
    localparam logic [1:0] CMD_LOOKUP  = 2'd1;
    localparam logic [1:0] CMD_CLEANUP = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    // Status codes carried in the result beat.
    localparam logic [2:0] ST_INSERTED     = 3'd0;
    localparam logic [2:0] ST_UPDATED      = 3'd1;
    localparam logic [2:0] ST_FULL         = 3'd2;
    localparam logic [2:0] ST_FOUND        = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND    = 3'd4;
    localparam logic [2:0] ST_REMOVED      = 3'd5;
    localparam logic [2:0] ST_NONE_REMOVED = 3'd6;

    // Register map: the word index of the stale limit register.
    localparam logic        REG_STALE_LIMIT   = 1'b0;
    localparam logic [31:0] STALE_LIMIT_RESET = 32'd3600;

    // Input beat.
    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] hash_high;
        logic [63:0] hash_low;
        logic [31:0] peer_address;
        logic [15:0] peer_port;
        logic [31:0] now_seconds;
    } in_item_t;

    // Result beat.
    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] out_hash_high;
        logic [63:0] out_hash_low;
        logic [31:0] out_address;
        logic [15:0] out_port;
        logic [31:0] out_last_seen;
        logic        last;
    } out_item_t;

    // One stored table entry.
    typedef struct packed {
        logic [127:0] key;
        logic [31:0]  address;
        logic [15:0]  port;
        logic [31:0]  seen;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic act_upsert;
        logic act_lookup;
        logic emit_found;
        logic clean_start;
        logic clean_step;
        logic clean_finish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] command;
        logic       hit;
        logic       walk_done;
    } dp_sts_t;

endpackage

// File: rtl/kpt_ctrl.sv
// Controller state machine of the keyed peer table.
// Depends on kpt_pkg for the command codes and the controller/datapath structs.
module kpt_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         command,
    input  kpt_pkg::dp_sts_t   sts,
    output kpt_pkg::dp_cmd_t   cmd,
    output logic               busy
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ACT   = 4'b0010,
        S_LOOK  = 4'b0100,
        S_CLEAN = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    case (command)
                        kpt_pkg::CMD_UPSERT,
                        kpt_pkg::CMD_LOOKUP:
                        begin
                            state_next = S_ACT;
                        end
                        kpt_pkg::CMD_CLEANUP:
                        begin
                            cmd.clean_start = 1'b1;
                            state_next      = S_CLEAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ACT:
            begin
                if (sts.command == kpt_pkg::CMD_UPSERT)
                begin
                    cmd.act_upsert = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.act_lookup = 1'b1;
                    state_next     = sts.hit ? S_LOOK : S_IDLE;
                end
            end
            S_LOOK:
            begin
                cmd.emit_found = 1'b1;
                state_next     = S_IDLE;
            end
            S_CLEAN:
            begin
                if (sts.walk_done)
                begin
                    cmd.clean_finish = 1'b1;
                    state_next       = S_IDLE;
                end
                else
                begin
                    cmd.clean_step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// File: rtl/kpt_dpath.sv
// Datapath of the keyed peer table: key compare lanes, entry memory, cleanup walk
// counters and the result register. Depends on kpt_pkg for beat types and structs.
module kpt_dpath
#(
    parameter int CAPACITY = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  kpt_pkg::dp_cmd_t    cmd,
    output kpt_pkg::dp_sts_t    sts,
    input  kpt_pkg::in_item_t   item,
    input  logic [31:0]         stale_limit,
    output kpt_pkg::out_item_t  result,
    output logic                result_valid
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Stored entries; the key copy in flops feeds the parallel compare lanes.
    kpt_pkg::entry_t    entry_mem [CAPACITY];
    logic [127:0]       cam_reg   [CAPACITY];
    kpt_pkg::entry_t    rd_data_reg;

    kpt_pkg::in_item_t  in_reg;
    kpt_pkg::in_item_t  in_next;
    logic [CAPACITY-1:0] match_reg;
    logic [CAPACITY-1:0] match_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   rd_idx_reg;
    logic [CNT_W-1:0]   rd_idx_next;
    logic [CNT_W-1:0]   wr_idx_reg;
    logic [CNT_W-1:0]   wr_idx_next;
    logic               pipe_vld_reg;
    logic               pipe_vld_next;
    logic               held_vld_reg;
    logic               held_vld_next;
    kpt_pkg::entry_t    held_reg;
    kpt_pkg::entry_t    held_next;
    kpt_pkg::out_item_t result_reg;
    kpt_pkg::out_item_t result_next;
    logic               result_valid_reg;
    logic               result_valid_next;

    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic               rd_more;
    logic [31:0]        age;
    logic               stale;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    kpt_pkg::entry_t    mem_wdata;
    logic               rd_en;
    logic [IDX_W-1:0]   mem_raddr;
    kpt_pkg::entry_t    in_entry;

    // Builds one result beat.
    function automatic kpt_pkg::out_item_t pack_result(input logic [2:0] st,
                                                       input kpt_pkg::entry_t e,
                                                       input logic lst);
        kpt_pkg::out_item_t r;
        r.status        = st;
        r.out_hash_high = e.key[127:64];
        r.out_hash_low  = e.key[63:0];
        r.out_address   = e.address;
        r.out_port      = e.port;
        r.out_last_seen = e.seen;
        r.last          = lst;
        return r;
    endfunction

    // Compare lanes: one equality compare per valid entry against the incoming key.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            match_next[i] = (cam_reg[i] == {item.hash_high, item.hash_low}) &&
                            (CNT_W'(i) < count_reg);
        end
    end

    // Priority encoder over the registered match vector; the lowest entry wins.
    always_comb
    begin
        hit_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign hit = |match_reg;

    // Aging test on the entry returned by the cleanup walk.
    assign age   = in_reg.now_seconds - rd_data_reg.seen;
    assign stale = (in_reg.now_seconds > rd_data_reg.seen) && (age > stale_limit);

    assign rd_more  = (rd_idx_reg < count_reg);
    assign in_entry = '{key:     {in_reg.hash_high, in_reg.hash_low},
                        address: in_reg.peer_address,
                        port:    in_reg.peer_port,
                        seen:    in_reg.now_seconds};

    // Memory port control.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = count_reg[IDX_W-1:0];
        mem_wdata = in_entry;
        if (cmd.act_upsert)
        begin
            if (hit)
            begin
                mem_we    = 1'b1;
                mem_waddr = hit_idx;
            end
            else if (count_reg != CAP_CNT)
            begin
                mem_we = 1'b1;
            end
        end
        else if (cmd.clean_step && pipe_vld_reg && !stale)
        begin
            mem_we    = 1'b1;
            mem_waddr = wr_idx_reg[IDX_W-1:0];
            mem_wdata = rd_data_reg;
        end
    end

    assign rd_en     = cmd.act_lookup || (cmd.clean_step && rd_more);
    assign mem_raddr = cmd.act_lookup ? hit_idx : rd_idx_reg[IDX_W-1:0];

    // Entry memory and key flops: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
            cam_reg[mem_waddr]   <= mem_wdata.key;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[mem_raddr];
        end
    end

    // Next-state logic for counters, the held removed entry and the result.
    always_comb
    begin
        in_next           = in_reg;
        count_next        = count_reg;
        rd_idx_next       = rd_idx_reg;
        wr_idx_next       = wr_idx_reg;
        pipe_vld_next     = 1'b0;
        held_vld_next     = held_vld_reg;
        held_next         = held_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;

        if (cmd.capture)
        begin
            in_next = item;
        end

        if (cmd.act_upsert)
        begin
            result_valid_next = 1'b1;
            if (hit)
            begin
                result_next = pack_result(kpt_pkg::ST_UPDATED, '0, 1'b1);
            end
            else if (count_reg == CAP_CNT)
            begin
                result_next = pack_result(kpt_pkg::ST_FULL, '0, 1'b1);
            end
            else
            begin
                result_next = pack_result(kpt_pkg::ST_INSERTED, '0, 1'b1);
                count_next  = count_reg + CNT_W'(1);
            end
        end

        if (cmd.act_lookup && !hit)
        begin
            result_valid_next = 1'b1;
            result_next       = pack_result(kpt_pkg::ST_NOT_FOUND, '0, 1'b1);
        end

        if (cmd.emit_found)
        begin
            result_valid_next = 1'b1;
            result_next       = pack_result(kpt_pkg::ST_FOUND, rd_data_reg, 1'b1);
        end

        if (cmd.clean_start)
        begin
            rd_idx_next   = '0;
            wr_idx_next   = '0;
            held_vld_next = 1'b0;
        end

        // One entry is read and one is judged per cycle of the walk.
        if (cmd.clean_step)
        begin
            pipe_vld_next = rd_more;
            if (rd_more)
            begin
                rd_idx_next = rd_idx_reg + CNT_W'(1);
            end
            if (pipe_vld_reg)
            begin
                if (stale)
                begin
                    if (held_vld_reg)
                    begin
                        result_valid_next = 1'b1;
                        result_next = pack_result(kpt_pkg::ST_REMOVED, held_reg, 1'b0);
                    end
                    held_next     = rd_data_reg;
                    held_vld_next = 1'b1;
                end
                else
                begin
                    wr_idx_next = wr_idx_reg + CNT_W'(1);
                end
            end
        end

        // The last removed entry carries the last mark.
        if (cmd.clean_finish)
        begin
            count_next        = wr_idx_reg;
            result_valid_next = 1'b1;
            if (held_vld_reg)
            begin
                result_next = pack_result(kpt_pkg::ST_REMOVED, held_reg, 1'b1);
            end
            else
            begin
                result_next = pack_result(kpt_pkg::ST_NONE_REMOVED, '0, 1'b1);
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            rd_idx_reg       <= '0;
            wr_idx_reg       <= '0;
            pipe_vld_reg     <= 1'b0;
            held_vld_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            rd_idx_reg       <= rd_idx_next;
            wr_idx_reg       <= wr_idx_next;
            pipe_vld_reg     <= pipe_vld_next;
            held_vld_reg     <= held_vld_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        in_reg     <= in_next;
        held_reg   <= held_next;
        result_reg <= result_next;
        if (cmd.capture)
        begin
            match_reg <= match_next;
        end
    end

    assign sts.command   = in_reg.command;
    assign sts.hit       = hit;
    assign sts.walk_done = !rd_more && !pipe_vld_reg;

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

// File: rtl/keyed_peer_table_with_aging_top.sv
// Top level of the keyed peer table with aging: register port, controller and datapath.
// Depends on kpt_pkg, kpt_ctrl and kpt_dpath.
//
//   Channel   Handshake             Payload
//   --------  --------------------  ----------------------------
//   input     start, busy           item   (kpt_pkg::in_item_t)
//   result    result_valid strobe   result (kpt_pkg::out_item_t)
//   config    psel/penable/pwrite   paddr, pwdata, prdata
//
// Upsert and lookup miss keep busy high through state S_ACT; a lookup hit also passes
// through S_LOOK for the registered read of the entry memory. Cleanup walks the table
// one entry per cycle through the memory read port, with busy high until the walk is
// done; on an empty table it goes straight to the finish step.
// A result beat follows in the cycle after the cycle that produced it and is never
// held; reset clears the table to empty and the stale limit to 3600 seconds.
module keyed_peer_table_with_aging_top
#(
    parameter int CAPACITY = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  kpt_pkg::in_item_t   item,
    output logic                busy,
    output logic                result_valid,
    output kpt_pkg::out_item_t  result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [31:0]       stale_limit_reg;
    logic [31:0]       stale_limit_next;
    logic              cfg_write;
    kpt_pkg::dp_cmd_t  dp_cmd;
    kpt_pkg::dp_sts_t  dp_sts;

    // Register port: bit 2 of the byte address selects the word.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        stale_limit_next = stale_limit_reg;
        if (cfg_write && (paddr[2] == kpt_pkg::REG_STALE_LIMIT))
        begin
            stale_limit_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_limit_reg <= kpt_pkg::STALE_LIMIT_RESET;
        end
        else
        begin
            stale_limit_reg <= stale_limit_next;
        end
    end

    assign prdata = (paddr[2] == kpt_pkg::REG_STALE_LIMIT) ? stale_limit_reg : '0;

    // Controller.
    kpt_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (item.command),
        .sts     (dp_sts),
        .cmd     (dp_cmd),
        .busy    (busy)
    );

    // Datapath.
    kpt_dpath
    #(
        .CAPACITY (CAPACITY)
    )
    u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .sts          (dp_sts),
        .item         (item),
        .stale_limit  (stale_limit_reg),
        .result       (result),
        .result_valid (result_valid)
    );

`ifndef SYNTH
    // A real command taken while idle always makes the block busy next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.command != kpt_pkg::CMD_NONE)) |=> busy)
        else $error("accepted command did not raise busy");

    // Every result beat is produced by a cycle of work.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result beat without preceding work");

    // Only removed entries can be followed by more beats of the same command.
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |-> (result.status == kpt_pkg::ST_REMOVED))
        else $error("non-final beat that is not a removed entry");
`endif

endmodule

// File: sim/tb_keyed_peer_table_with_aging_top.sv
// Self-checking testbench for keyed_peer_table_with_aging_top: directed, table-full,
// stale-limit and random traffic checked beat by beat against an in-bench table model.
// Depends on kpt_pkg and the RTL of the block.
module tb_keyed_peer_table_with_aging_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_POOL_SIZE = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] STALE_LIMIT_ADDR = {kpt_pkg::REG_STALE_LIMIT, 2'b00};

    logic               clk;
    logic               rst_n;
    logic               start;
    kpt_pkg::in_item_t  item;
    logic               busy;
    logic               result_valid;
    kpt_pkg::out_item_t result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // Table model: entries in insertion order plus the stale limit register.
    logic [127:0] peer_key[TABLE_DEPTH];
    logic [31:0]  peer_addr[TABLE_DEPTH];
    logic [15:0]  peer_port[TABLE_DEPTH];
    logic [31:0]  peer_seen[TABLE_DEPTH];
    int           peer_count;
    logic [31:0]  stale_limit;

    kpt_pkg::out_item_t expected_beats[$];
    logic [127:0] key_pool[KEY_POOL_SIZE];
    logic [31:0]  time_base;
    int           idle_max;
    int           error_count = 0;
    int           cycle_count = 0;

    keyed_peer_table_with_aging_top #(
        .CAPACITY (TABLE_DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic kpt_pkg::in_item_t make_item(logic [1:0] cmd, logic [127:0] key,
                                                    logic [31:0] addr, logic [15:0] port,
                                                    logic [31:0] now);
        kpt_pkg::in_item_t it;
        it.command      = cmd;
        it.hash_high    = key[127:64];
        it.hash_low     = key[63:0];
        it.peer_address = addr;
        it.peer_port    = port;
        it.now_seconds  = now;
        return it;
    endfunction

    function automatic logic [127:0] random_key();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic int find_peer(logic [127:0] key);
        for (int i = 0; i < peer_count; i++)
            if (peer_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic logic bool_stale(logic [31:0] now, logic [31:0] seen);
        // An entry stamped ahead of the current time is never stale.
        return now > seen && (now - seen) > stale_limit;
    endfunction

    // Appends one beat to the tail of the expected queue.
    function automatic void queue_expected(kpt_pkg::out_item_t beat);
        expected_beats.insert(expected_beats.size(), beat);
    endfunction

    // Applies one accepted command to the table model and queues its result beats.
    function automatic void predict_table_op(kpt_pkg::in_item_t it);
        logic [127:0]       key;
        kpt_pkg::out_item_t beat;
        int                 idx;
        int                 keep;
        int                 stale_total;
        int                 removed;
        key  = {it.hash_high, it.hash_low};
        beat = '0;
        beat.last = 1'b1;
        case (it.command)
            kpt_pkg::CMD_UPSERT:
            begin
                idx = find_peer(key);
                if (idx >= 0)
                begin
                    peer_addr[idx] = it.peer_address;
                    peer_port[idx] = it.peer_port;
                    peer_seen[idx] = it.now_seconds;
                    beat.status = kpt_pkg::ST_UPDATED;
                end
                else if (peer_count >= TABLE_DEPTH)
                    beat.status = kpt_pkg::ST_FULL;
                else
                begin
                    peer_key[peer_count]  = key;
                    peer_addr[peer_count] = it.peer_address;
                    peer_port[peer_count] = it.peer_port;
                    peer_seen[peer_count] = it.now_seconds;
                    peer_count++;
                    beat.status = kpt_pkg::ST_INSERTED;
                end
                queue_expected(beat);
            end
            kpt_pkg::CMD_LOOKUP:
            begin
                idx = find_peer(key);
                if (idx >= 0)
                begin
                    beat.status        = kpt_pkg::ST_FOUND;
                    beat.out_hash_high = peer_key[idx][127:64];
                    beat.out_hash_low  = peer_key[idx][63:0];
                    beat.out_address   = peer_addr[idx];
                    beat.out_port      = peer_port[idx];
                    beat.out_last_seen = peer_seen[idx];
                end
                else
                    beat.status = kpt_pkg::ST_NOT_FOUND;
                queue_expected(beat);
            end
            kpt_pkg::CMD_CLEANUP:
            begin
                // Count first so the final removed beat can carry the last mark.
                stale_total = 0;
                for (int i = 0; i < peer_count; i++)
                    if (bool_stale(it.now_seconds, peer_seen[i]))
                        stale_total++;
                keep    = 0;
                removed = 0;
                for (int i = 0; i < peer_count; i++)
                begin
                    if (bool_stale(it.now_seconds, peer_seen[i]))
                    begin
                        removed++;
                        beat.status        = kpt_pkg::ST_REMOVED;
                        beat.out_hash_high = peer_key[i][127:64];
                        beat.out_hash_low  = peer_key[i][63:0];
                        beat.out_address   = peer_addr[i];
                        beat.out_port      = peer_port[i];
                        beat.out_last_seen = peer_seen[i];
                        beat.last          = (removed == stale_total);
                        queue_expected(beat);
                    end
                    else
                    begin
                        peer_key[keep]  = peer_key[i];
                        peer_addr[keep] = peer_addr[i];
                        peer_port[keep] = peer_port[i];
                        peer_seen[keep] = peer_seen[i];
                        keep++;
                    end
                end
                peer_count = keep;
                if (stale_total == 0)
                begin
                    beat = '0;
                    beat.status = kpt_pkg::ST_NONE_REMOVED;
                    beat.last   = 1'b1;
                    queue_expected(beat);
                end
            end
            default:
            begin
                // The unused command code is dropped without a result.
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // Every result beat is compared with the oldest expected beat.
    always @(posedge clk)
    begin : result_check
        kpt_pkg::out_item_t want;
        if (rst_n && result_valid)
        begin
            if (expected_beats.size() == 0)
            begin
                error_count++;
                $display("%0t ns: unexpected result beat, expected none, actual %p",
                         $time, result);
            end
            else
            begin
                want = expected_beats.pop_front();
                check_field("status", 64'(want.status), 64'(result.status));
                check_field("out_hash_high", want.out_hash_high, result.out_hash_high);
                check_field("out_hash_low", want.out_hash_low, result.out_hash_low);
                check_field("out_address", 64'(want.out_address), 64'(result.out_address));
                check_field("out_port", 64'(want.out_port), 64'(result.out_port));
                check_field("out_last_seen", 64'(want.out_last_seen),
                            64'(result.out_last_seen));
                check_field("last", 64'(want.last), 64'(result.last));
            end
        end
    end

    // Presents one command after a random gap and returns at the edge that takes it.
    // start is left high so that a following beat can go out back to back.
    task automatic send_item(kpt_pkg::in_item_t it);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        // busy is settled by the falling edge, so an idle block takes the beat next.
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        predict_table_op(it);
    endtask

    task automatic wait_results_done();
        start <= 1'b0;
        @(posedge clk);
        while (expected_beats.size() != 0)
            @(posedge clk);
    endtask

    // Full drain: no beat outstanding and the block back to idle.
    task automatic drain_table();
        wait_results_done();
        while (busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_stale_limit(logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= STALE_LIMIT_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        stale_limit = value;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_stale_limit();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= STALE_LIMIT_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        check_field("stale limit readback", 64'(stale_limit), 64'(prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mixed random commands over a small key pool so that updates and hits are common.
    task automatic run_random_traffic(int n_items, int max_step);
        kpt_pkg::in_item_t it;
        logic [127:0]      key;
        int                pick;
        int                done;
        done = 0;
        while (done < n_items)
        begin
            if ($urandom_range(0, 19) == 0)
                idle_max = (idle_max == 0) ? 7 : 0;
            if ($urandom_range(0, 29) == 0)
                wait_results_done();
            time_base += $urandom_range(0, max_step);
            key  = ($urandom_range(0, 9) == 0) ? random_key()
                                               : key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
            pick = $urandom_range(0, 99);
            it = make_item(pick < 45 ? kpt_pkg::CMD_UPSERT : pick < 75 ? kpt_pkg::CMD_LOOKUP :
                           pick < 90 ? kpt_pkg::CMD_CLEANUP : kpt_pkg::CMD_NONE,
                           key, $urandom, 16'($urandom),
                           time_base - $urandom_range(0, max_step));
            // An occasional wild timestamp exercises every bit of the time field.
            if ($urandom_range(0, 15) == 0)
                it.now_seconds = $urandom;
            send_item(it);
            if (it.command != kpt_pkg::CMD_NONE)
                done++;
        end
        drain_table();
    endtask

    // Field extremes, every command, misses, the ignored code and both cleanup outcomes.
    task automatic test_directed_cases();
        logic [127:0] k_zero;
        logic [127:0] k_ones;
        logic [127:0] k_high;
        logic [127:0] k_low;
        k_zero = '0;
        k_ones = '1;
        k_high = {64'hFFFF_FFFF_FFFF_FFFF, 64'h0};
        k_low  = {64'h0, 64'hFFFF_FFFF_FFFF_FFFF};
        idle_max = 7;
        send_item(make_item(kpt_pkg::CMD_LOOKUP, k_zero, 32'h0, 16'h0, 32'h0));
        send_item(make_item(kpt_pkg::CMD_CLEANUP, k_zero, 32'h0, 16'h0, 32'h0));
        send_item(make_item(kpt_pkg::CMD_UPSERT, k_zero, 32'h0, 16'h0, 32'h0));
        send_item(make_item(kpt_pkg::CMD_UPSERT, k_ones, 32'hFFFF_FFFF, 16'hFFFF,
                            32'hFFFF_FFFF));
        send_item(make_item(kpt_pkg::CMD_UPSERT, k_high, 32'h0A00_0001, 16'd4662, 32'd1000));
        send_item(make_item(kpt_pkg::CMD_UPSERT, k_zero, 32'hC0A8_0001, 16'd80, 32'd5000));
        send_item(make_item(kpt_pkg::CMD_LOOKUP, k_zero, 32'h0, 16'h0, 32'h0));
        send_item(make_item(kpt_pkg::CMD_LOOKUP, k_ones, 32'h0, 16'h0, 32'h0));
        send_item(make_item(kpt_pkg::CMD_LOOKUP, k_low, 32'h0, 16'h0, 32'h0));
        send_item(make_item(kpt_pkg::CMD_NONE, k_ones, 32'hFFFF_FFFF, 16'hFFFF,
                            32'hFFFF_FFFF));
        // One stale entry; the entry stamped in the future must survive.
        send_item(make_item(kpt_pkg::CMD_CLEANUP, k_zero, 32'h0, 16'h0, 32'd5000));
        send_item(make_item(kpt_pkg::CMD_UPSERT, k_low, 32'h1234_5678, 16'd1, 32'd100));
        send_item(make_item(kpt_pkg::CMD_UPSERT, k_high, 32'h8765_4321, 16'd2, 32'd200));
        // Several stale entries with a survivor in between.
        send_item(make_item(kpt_pkg::CMD_CLEANUP, k_zero, 32'h0, 16'h0, 32'hFFFF_FFFF));
        send_item(make_item(kpt_pkg::CMD_LOOKUP, k_ones, 32'h0, 16'h0, 32'h0));
        send_item(make_item(kpt_pkg::CMD_LOOKUP, k_zero, 32'h0, 16'h0, 32'h0));
        drain_table();
    endtask

    // Fill the table, overflow it, update while full, then age it out in two halves.
    task automatic test_table_full();
        logic [127:0] key;
        logic [31:0]  t0;
        int           fills;
        t0 = $urandom_range(0, 32'h7FFF_FFFF);
        fills = 0;
        idle_max = 3;
        while (peer_count < TABLE_DEPTH)
        begin
            key = random_key();
            send_item(make_item(kpt_pkg::CMD_UPSERT, key, $urandom, 16'($urandom),
                                (fills < TABLE_DEPTH / 2) ? t0 : t0 + 32'd3000));
            fills++;
        end
        send_item(make_item(kpt_pkg::CMD_UPSERT, random_key(), $urandom, 16'($urandom), t0));
        send_item(make_item(kpt_pkg::CMD_UPSERT, key, $urandom, 16'($urandom),
                            t0 + 32'd3000));
        send_item(make_item(kpt_pkg::CMD_LOOKUP, key, 32'h0, 16'h0, 32'h0));
        send_item(make_item(kpt_pkg::CMD_CLEANUP, key, 32'h0, 16'h0, t0 + 32'd3700));
        send_item(make_item(kpt_pkg::CMD_CLEANUP, key, 32'h0, 16'h0, t0 + 32'd100000));
        drain_table();
    endtask

    // Reset value readback, then traffic under the smallest and largest limits.
    task automatic test_stale_limit_settings();
        read_stale_limit();
        write_stale_limit(32'h0);
        read_stale_limit();
        idle_max = 7;
        run_random_traffic(6, 20);
        write_stale_limit(32'hFFFF_FFFF);
        read_stale_limit();
        run_random_traffic(6, 2000);
    endtask

    task automatic test_random_traffic();
        write_stale_limit($urandom_range(20, 400));
        read_stale_limit();
        idle_max = 7;
        run_random_traffic(10, 60);
    endtask

    initial
    begin
        rst_n   <= 1'b0;
        start   <= 1'b0;
        item    <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        peer_count  = 0;
        stale_limit = kpt_pkg::STALE_LIMIT_RESET;
        idle_max    = 7;
        time_base   = $urandom;
        for (int i = 0; i < KEY_POOL_SIZE; i++)
            key_pool[i] = random_key();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_table_full();
        test_stale_limit_settings();
        test_random_traffic();

        drain_table();
        repeat (16) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/kpt_pkg.sv
rtl/kpt_ctrl.sv
rtl/kpt_dpath.sv
rtl/keyed_peer_table_with_aging_top.sv
sim/tb_keyed_peer_table_with_aging_top.sv
